// ----- sv/rmm_pkg.sv -----
// shared types, operation codes and helper functions for the random math and merge alu
// no dependencies
package rmm_pkg;

  // request and result payloads
  typedef struct packed {
    logic        req_type;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] math_select;
    logic [31:0] merge_target;
    logic [31:0] merge_select;
  } req_t;

  typedef struct packed {
    logic [31:0] math_value;
    logic [31:0] merged_value;
  } rsp_t;

  // math operation codes, math_select mod 11
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_MULL = 4'd1,
    OP_MULH = 4'd2,
    OP_MIN  = 4'd3,
    OP_ROTL = 4'd4,
    OP_ROTR = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_XOR  = 4'd8,
    OP_CLZ  = 4'd9,
    OP_POPC = 4'd10
  } math_op_e;

  // merge codes, merge_select mod 4
  typedef enum logic [1:0] {
    MRG_MUL_ADD = 2'd0,
    MRG_XOR_MUL = 2'd1,
    MRG_ROTL    = 2'd2,
    MRG_ROTR    = 2'd3
  } merge_op_e;

  // all candidate math results for one request
  typedef struct packed {
    logic [31:0] sum;
    logic [31:0] prod_lo;
    logic [31:0] prod_hi;
    logic [31:0] min_val;
    logic [31:0] rotl_val;
    logic [31:0] rotr_val;
    logic [31:0] and_val;
    logic [31:0] or_val;
    logic [31:0] xor_val;
    logic [6:0]  clz_sum;
    logic [6:0]  popc_sum;
  } ops_t;

  // first pass of mod 11: 256^i mod 11 is 1, 3, 9, 5
  function automatic logic [12:0] mod11_partial(input logic [31:0] x);
    logic [12:0] s;
    s = 13'(x[7:0]) + 13'(x[15:8]) * 13'd3 + 13'(x[23:16]) * 13'd9
      + 13'(x[31:24]) * 13'd5;
    return s;
  endfunction

  // second pass of mod 11 on the partial sum, ends with binary restoring steps
  function automatic logic [3:0] mod11_final(input logic [12:0] s);
    logic [8:0] v1;
    logic [7:0] v2;
    v1 = 9'(s[7:0]) + 9'(s[12:8]) * 9'd3;
    // 16 mod 11 is 5, result stays below 176
    v2 = 8'(v1[3:0]) + 8'(v1[8:4]) * 8'd5;
    if (v2 >= 8'd88) v2 = v2 - 8'd88;
    if (v2 >= 8'd44) v2 = v2 - 8'd44;
    if (v2 >= 8'd22) v2 = v2 - 8'd22;
    if (v2 >= 8'd11) v2 = v2 - 8'd11;
    return v2[3:0];
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    return (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    return (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

  // leading zeros by binary search, zero gives 32
  function automatic logic [5:0] clz32(input logic [31:0] x);
    logic [5:0]  n;
    logic [31:0] y;
    n = 6'd0;
    y = x;
    if (y[31:16] == 16'd0) begin n = n + 6'd16; y = y << 16; end
    if (y[31:24] == 8'd0) begin n = n + 6'd8; y = y << 8; end
    if (y[31:28] == 4'd0) begin n = n + 6'd4; y = y << 4; end
    if (y[31:30] == 2'd0) begin n = n + 6'd2; y = y << 2; end
    if (!y[31]) begin n = n + 6'd1; y = y << 1; end
    if (!y[31]) n = n + 6'd1;
    return n;
  endfunction

  // population count: nibble counts, then a short sum
  function automatic logic [5:0] popc32(input logic [31:0] x);
    logic [2:0] nib [8];
    logic [5:0] n;
    for (int i = 0; i < 8; i++) begin
      nib[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
    end
    n = 6'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 6'(nib[i]);
    end
    return n;
  endfunction

endpackage

// ----- sv/random_math_merge_alu.sv -----
// top level of the random math and merge alu: four-stage pipeline
// depends on rmm_pkg and rmm_ops
//
// Stateless 32-bit ALU that takes one request per cycle while the output is not stalled
// and returns one result per request, in order, from the stage 4 result register.
// Stage 1 reduces math_select toward its mod 11 code; stage 2 finishes the code and
// computes every math candidate, with the 32x32 multiplier setting the clock path;
// stage 3 selects the math value, or operand_b if req_type is clear; stage 4 merges
// it into merge_target and holds the result. A stall on the output backs up stage by
// stage, so the block keeps taking requests until all four stages are full.
module random_math_merge_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rmm_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rmm_pkg::rsp_t out_rsp_o
);

  // stage valid bits and advance conditions
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o  = !adv1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // stage 1: capture request, partial mod 11 of math_select
  rmm_pkg::req_t r1_q;
  logic [12:0]   mod1_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      r1_q   <= in_req_i;
      mod1_q <= rmm_pkg::mod11_partial(in_req_i.math_select);
    end
  end

  // stage 2: operation code, math candidates, merge precomputation
  rmm_pkg::ops_t     ops1;
  rmm_pkg::ops_t     ops2_q;
  rmm_pkg::math_op_e code2_q;
  logic              req2_q;
  logic [31:0]       b2_q;
  logic [31:0]       t2_q;
  logic [31:0]       t33_2_q;
  logic [31:0]       trl2_q;
  logic [31:0]       trr2_q;
  rmm_pkg::merge_op_e mcode2_q;

  rmm_ops u_ops (
    .a_i  (r1_q.operand_a),
    .b_i  (r1_q.operand_b),
    .ops_o(ops1)
  );

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      ops2_q   <= ops1;
      code2_q  <= rmm_pkg::math_op_e'(rmm_pkg::mod11_final(mod1_q));
      req2_q   <= r1_q.req_type;
      b2_q     <= r1_q.operand_b;
      t2_q     <= r1_q.merge_target;
      t33_2_q  <= (r1_q.merge_target << 5) + r1_q.merge_target;
      trl2_q   <= rmm_pkg::rotl32(r1_q.merge_target, r1_q.merge_select[20:16]);
      trr2_q   <= rmm_pkg::rotr32(r1_q.merge_target, r1_q.merge_select[20:16]);
      mcode2_q <= rmm_pkg::merge_op_e'(r1_q.merge_select[1:0]);
    end
  end

  // stage 3: select the math value, or operand_b when req_type is clear
  logic [31:0]        math_sel;
  logic [31:0]        val3_q;
  logic [31:0]        t3_q;
  logic [31:0]        t33_3_q;
  logic [31:0]        trl3_q;
  logic [31:0]        trr3_q;
  rmm_pkg::merge_op_e mcode3_q;

  always_comb begin
    unique case (code2_q)
      rmm_pkg::OP_ADD:  math_sel = ops2_q.sum;
      rmm_pkg::OP_MULL: math_sel = ops2_q.prod_lo;
      rmm_pkg::OP_MULH: math_sel = ops2_q.prod_hi;
      rmm_pkg::OP_MIN:  math_sel = ops2_q.min_val;
      rmm_pkg::OP_ROTL: math_sel = ops2_q.rotl_val;
      rmm_pkg::OP_ROTR: math_sel = ops2_q.rotr_val;
      rmm_pkg::OP_AND:  math_sel = ops2_q.and_val;
      rmm_pkg::OP_OR:   math_sel = ops2_q.or_val;
      rmm_pkg::OP_XOR:  math_sel = ops2_q.xor_val;
      rmm_pkg::OP_CLZ:  math_sel = 32'(ops2_q.clz_sum);
      rmm_pkg::OP_POPC: math_sel = 32'(ops2_q.popc_sum);
      default:          math_sel = ops2_q.sum;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      val3_q   <= req2_q ? math_sel : b2_q;
      t3_q     <= t2_q;
      t33_3_q  <= t33_2_q;
      trl3_q   <= trl2_q;
      trr3_q   <= trr2_q;
      mcode3_q <= mcode2_q;
    end
  end

  // stage 4: merge into the target and hold the result
  logic [31:0] tx;
  logic [31:0] merged;
  rmm_pkg::rsp_t rsp4_q;

  assign tx = t3_q ^ val3_q;

  always_comb begin
    unique case (mcode3_q)
      rmm_pkg::MRG_MUL_ADD: merged = t33_3_q + val3_q;
      rmm_pkg::MRG_XOR_MUL: merged = (tx << 5) + tx;
      rmm_pkg::MRG_ROTL:    merged = trl3_q ^ val3_q;
      rmm_pkg::MRG_ROTR:    merged = trr3_q ^ val3_q;
      default:              merged = trr3_q ^ val3_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      rsp4_q.math_value   <= val3_q;
      rsp4_q.merged_value <= merged;
    end
  end

  assign out_rsp_o = rsp4_q;

endmodule

// ----- sv/rmm_ops.sv -----
// candidate math results for one operand pair, including the 32x32 product
// depends on rmm_pkg
module rmm_ops (
  input  logic [31:0]   a_i,
  input  logic [31:0]   b_i,
  output rmm_pkg::ops_t ops_o
);

  logic [63:0] prod;

  // full product serves both multiply low and multiply high
  assign prod = 64'(a_i) * 64'(b_i);

  always_comb begin
    ops_o.sum      = a_i + b_i;
    ops_o.prod_lo  = prod[31:0];
    ops_o.prod_hi  = prod[63:32];
    ops_o.min_val  = (a_i < b_i) ? a_i : b_i;
    ops_o.rotl_val = rmm_pkg::rotl32(a_i, b_i[4:0]);
    ops_o.rotr_val = rmm_pkg::rotr32(a_i, b_i[4:0]);
    ops_o.and_val  = a_i & b_i;
    ops_o.or_val   = a_i | b_i;
    ops_o.xor_val  = a_i ^ b_i;
    ops_o.clz_sum  = 7'(rmm_pkg::clz32(a_i)) + 7'(rmm_pkg::clz32(b_i));
    ops_o.popc_sum = 7'(rmm_pkg::popc32(a_i)) + 7'(rmm_pkg::popc32(b_i));
  end

endmodule
